### hw/rtl/sacl_pkg.sv
package sacl_pkg;

  localparam int unsigned MaxSetBits = 8;
  localparam int unsigned Ways       = 8;
  localparam int unsigned NumSets    = 1 << MaxSetBits;
  localparam int unsigned SetIdxW    = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int unsigned WayIdxW    = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned WayCntW    = $clog2(Ways + 1);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 6;
  localparam int unsigned TagW       = 64;
  localparam int unsigned StampW     = 32;
  localparam int unsigned CountW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_BLOCK_BITS  = 2'd1,
    CFG_ACTIVE_WAYS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              valid;
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
  } line_t;

  typedef line_t [Ways-1:0] row_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic              first_hit;
    logic              first_evicted;
    logic              second_hit;
    logic [CountW-1:0] hits_total;
    logic [CountW-1:0] misses_total;
    logic [CountW-1:0] evictions_total;
  } rsp_t;

endpackage

### hw/rtl/set_assoc_cache_lru_sim.sv
// After reset the block sweeps the tag store once, one set per cycle, over all NumSets sets
// (256 at the default geometry), with busy high; configuration writes are taken meanwhile.
// One access passes through a split step, a set read step, a scan of the ways in turn until a
// hit or the last active way, and a write-back step; a modify repeats the read, scan and write.
// The strobe follows the last write-back; busy drops with it; the receiver cannot stall it.
module set_assoc_cache_lru_sim import sacl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                rsp_valid_o,
  output rsp_t                rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e              state_q;
  logic [SetIdxW-1:0]  clr_q;
  logic [3:0]          set_bits_q;
  logic [5:0]          block_bits_q;
  logic [3:0]          active_ways_q;
  logic                kind_q;
  logic [63:0]         addr_q;
  logic [TagW-1:0]     tag_q;
  logic [SetIdxW-1:0]  set_q;
  logic                pass_q;
  logic [WayIdxW-1:0]  way_q;
  logic [WayIdxW-1:0]  pick_q;
  logic [StampW-1:0]   min_q;
  logic                hit_q;
  logic [StampW-1:0]   stamp_q;
  logic [CountW-1:0]   hit_cnt_q;
  logic [CountW-1:0]   miss_cnt_q;
  logic [CountW-1:0]   evict_cnt_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q;

  logic [3:0]          sb;
  logic [6:0]          shift_amt;
  logic [TagW-1:0]     tag_calc;
  logic [63:0]         set_full;
  logic [12:0]         set_mask;
  logic [SetIdxW-1:0]  set_calc;
  logic [WayCntW-1:0]  wcnt;
  logic [WayIdxW-1:0]  wlast;
  row_t                rd_row;
  row_t                wr_row;
  line_t               cur_line;
  line_t               pick_line;
  logic                mem_we;
  logic                mem_re;
  logic [SetIdxW-1:0]  mem_waddr;
  logic                evict_now;

  // Address split: clamp the set width, then form the tag and the set index.
  always_comb begin
    sb        = (set_bits_q > 4'(MaxSetBits)) ? 4'(MaxSetBits) : set_bits_q;
    shift_amt = {3'b000, sb} + {1'b0, block_bits_q};
    tag_calc  = (shift_amt >= 7'd64) ? '0 : (addr_q >> shift_amt[5:0]);
    set_full  = addr_q >> block_bits_q;
    set_mask  = (13'd1 << sb) - 13'd1;
    set_calc  = set_full[SetIdxW-1:0] & set_mask[SetIdxW-1:0];
  end

  always_comb begin
    if (active_ways_q == 4'd0) begin
      wcnt = WayCntW'(1);
    end else if (32'(active_ways_q) > Ways) begin
      wcnt = WayCntW'(Ways);
    end else begin
      wcnt = WayCntW'(active_ways_q);
    end
    wlast = WayIdxW'(wcnt - WayCntW'(1));
  end

  assign cur_line  = rd_row[way_q];
  assign pick_line = rd_row[pick_q];
  assign evict_now = !hit_q && pick_line.valid;

  // Write-back row: zeros while clearing; restamp on a hit, refill the victim on a miss.
  always_comb begin
    wr_row = rd_row;
    if (state_q == ST_CLEAR) begin
      wr_row = '0;
    end else begin
      wr_row[pick_q].stamp = stamp_q;
      if (!hit_q) begin
        wr_row[pick_q].valid = 1'b1;
        wr_row[pick_q].tag   = tag_q;
      end
    end
  end

  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign mem_re    = (state_q == ST_READ);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;

  sacl_set_ram u_set_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_row),
    .re_i    (mem_re),
    .raddr_i (set_q),
    .rdata_o (rd_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      set_bits_q    <= 4'd0;
      block_bits_q  <= 6'd0;
      active_ways_q <= 4'd1;
      kind_q        <= 1'b0;
      addr_q        <= '0;
      tag_q         <= '0;
      set_q         <= '0;
      pass_q        <= 1'b0;
      way_q         <= '0;
      pick_q        <= '0;
      min_q         <= '0;
      hit_q         <= 1'b0;
      stamp_q       <= StampW'(1);
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      evict_cnt_q   <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_q         <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SET_BITS:    set_bits_q    <= cfg_data_i[3:0];
          CFG_BLOCK_BITS:  block_bits_q  <= cfg_data_i;
          CFG_ACTIVE_WAYS: active_ways_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == NumSets - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            kind_q                <= req_i.kind;
            addr_q                <= req_i.address;
            pass_q                <= 1'b0;
            rsp_q.first_hit       <= 1'b0;
            rsp_q.first_evicted   <= 1'b0;
            rsp_q.second_hit      <= 1'b0;
            state_q               <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          tag_q   <= tag_calc;
          set_q   <= set_calc;
          state_q <= ST_READ;
        end
        ST_READ: begin
          way_q   <= '0;
          pick_q  <= '0;
          hit_q   <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cur_line.valid && (cur_line.tag == tag_q)) begin
            hit_q   <= 1'b1;
            pick_q  <= way_q;
            state_q <= ST_WRITE;
          end else begin
            // Strict compare keeps the lowest way on equal stamps.
            if (way_q == '0) begin
              pick_q <= '0;
              min_q  <= cur_line.stamp;
            end else if (cur_line.stamp < min_q) begin
              pick_q <= way_q;
              min_q  <= cur_line.stamp;
            end
            if (way_q == wlast) begin
              state_q <= ST_WRITE;
            end else begin
              way_q <= way_q + 1'b1;
            end
          end
        end
        ST_WRITE: begin
          stamp_q <= stamp_q + 1'b1;
          if (hit_q) begin
            hit_cnt_q <= hit_cnt_q + 1'b1;
          end else begin
            miss_cnt_q <= miss_cnt_q + 1'b1;
          end
          if (evict_now) begin
            evict_cnt_q <= evict_cnt_q + 1'b1;
          end
          if (!pass_q) begin
            rsp_q.first_hit     <= hit_q;
            rsp_q.first_evicted <= evict_now;
          end else begin
            rsp_q.second_hit    <= hit_q;
          end
          rsp_q.hits_total      <= hit_cnt_q + CountW'(hit_q);
          rsp_q.misses_total    <= miss_cnt_q + CountW'(!hit_q);
          rsp_q.evictions_total <= evict_cnt_q + CountW'(evict_now);
          if (kind_q && !pass_q) begin
            pass_q  <= 1'b1;
            state_q <= ST_READ;
          end else begin
            rsp_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  // Geometry changes are held off while a request is being looked up.
  assign cfg_ready_o = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The first access of a modify leaves the line resident, so the second one must hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && kind_q |-> rsp_q.second_hit)
    else $error("second access of a modify missed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_q.first_hit && rsp_q.first_evicted))
    else $error("eviction reported on a hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> way_q <= wlast)
    else $error("way scan ran past the active ways");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |=> !rsp_valid_q)
    else $error("result strobe held longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |=> stamp_q == $past(stamp_q) + StampW'(1))
    else $error("stamp counter did not advance on a write-back");

endmodule

### hw/rtl/sacl_set_ram.sv
module sacl_set_ram import sacl_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [SetIdxW-1:0] waddr_i,
  input  row_t               wdata_i,
  input  logic               re_i,
  input  logic [SetIdxW-1:0] raddr_i,
  output row_t               rdata_o
);

  row_t mem [NumSets];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
